// ----- hdl/scale_note_quantizer_macros.svh -----
// assertion macros used by the checker of the quantizer
`ifndef SCALE_NOTE_QUANTIZER_MACROS_SVH
`define SCALE_NOTE_QUANTIZER_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define SNQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("snq check failed");

// antecedent holds, consequent holds in the next cycle
`define SNQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("snq check failed");

`endif

// ----- hdl/snq_pkg.sv -----
package snq_pkg;

    localparam int NOTE_W          = 16;
    localparam int VALUE_W         = 18;
    localparam int BASE_W          = 6;
    localparam int MODE_W          = 3;
    localparam int MASK_W          = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_DEGREES_DEF = 64;
    localparam int STAGE_BITS      = 4;
    localparam int DIV_STAGES      = NOTE_W / STAGE_BITS;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(12);

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 3'd0,
        MODE_STEP_DN  = 3'd1,
        MODE_STEP_UP  = 3'd2,
        MODE_SCALE_DN = 3'd3,
        MODE_SCALE_UP = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 2'd0,
        REG_MODE = 2'd1,
        REG_MASK = 2'd2
    } cfg_reg_t;

    // item moving through the remainder stages
    typedef struct packed {
        logic              valid;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] pend;
        logic [BASE_W-1:0] rem;
    } div_item_t;

    // item leaving the search stage
    typedef struct packed {
        logic              valid;
        logic              in_scale;
        logic              step_dn;
        logic              step_up;
        logic              wrap_dn;
        logic              wrap_up;
        logic [NOTE_W-1:0] note;
        logic [BASE_W-1:0] rem;
        logic [BASE_W-1:0] ndeg;
    } sel_item_t;

endpackage

// ----- hdl/snq_rem_stage.sv -----
module snq_rem_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic [snq_pkg::BASE_W-1:0]      base,
    input  snq_pkg::div_item_t              item_in,
    output snq_pkg::div_item_t              item_out
);

    snq_pkg::div_item_t                item_reg;
    snq_pkg::div_item_t                item_next;
    logic [snq_pkg::BASE_W-1:0]        rem_c;
    logic [snq_pkg::NOTE_W-1:0]        pend_c;
    logic [snq_pkg::BASE_W:0]          trial_c;

    // restoring remainder, one note bit per step, msb first
    always_comb begin
        rem_c   = item_in.rem;
        pend_c  = item_in.pend;
        trial_c = '0;
        for (int i = 0; i < snq_pkg::STAGE_BITS; i++) begin
            trial_c = {rem_c, pend_c[snq_pkg::NOTE_W-1]};
            pend_c  = {pend_c[snq_pkg::NOTE_W-2:0], 1'b0};
            if (trial_c >= {1'b0, base}) begin
                trial_c = trial_c - {1'b0, base};
            end
            rem_c = trial_c[snq_pkg::BASE_W-1:0];
        end
        item_next       = item_in;
        item_next.pend  = pend_c;
        item_next.rem   = rem_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ----- hdl/snq_search.sv -----
module snq_search #(
    parameter int MAX_DEGREES = snq_pkg::MAX_DEGREES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic [snq_pkg::BASE_W-1:0]      base,
    input  logic [snq_pkg::MODE_W-1:0]      mode,
    input  logic [MAX_DEGREES-1:0]          mask,
    input  logic                            mask_any,
    input  snq_pkg::div_item_t              item_in,
    output snq_pkg::sel_item_t              item_out
);

    snq_pkg::sel_item_t            item_reg;
    snq_pkg::sel_item_t            item_next;
    snq_pkg::mode_t                mode_eff;
    logic [MAX_DEGREES-1:0]        vm;
    logic [MAX_DEGREES-1:0]        lower;
    logic [MAX_DEGREES-1:0]        upper;
    logic                          member;
    logic [snq_pkg::BASE_W-1:0]    hi_lower;
    logic [snq_pkg::BASE_W-1:0]    hi_all;
    logic [snq_pkg::BASE_W-1:0]    lo_upper;
    logic [snq_pkg::BASE_W-1:0]    lo_all;

    // scale bits below base, split around the current degree
    always_comb begin
        member = 1'b0;
        for (int i = 0; i < MAX_DEGREES; i++) begin
            vm[i]    = mask[i] && (snq_pkg::BASE_W'(i) < base);
            lower[i] = vm[i] && (snq_pkg::BASE_W'(i) < item_in.rem);
            upper[i] = vm[i] && (snq_pkg::BASE_W'(i) > item_in.rem);
            member   = member | (vm[i] && (snq_pkg::BASE_W'(i) == item_in.rem));
        end
    end

    // nearest member below and above, with wrap candidates
    always_comb begin
        hi_lower = '0;
        hi_all   = '0;
        lo_upper = '0;
        lo_all   = '0;
        for (int i = 0; i < MAX_DEGREES; i++) begin
            if (lower[i]) begin
                hi_lower = snq_pkg::BASE_W'(i);
            end
            if (vm[i]) begin
                hi_all = snq_pkg::BASE_W'(i);
            end
        end
        for (int i = MAX_DEGREES - 1; i >= 0; i--) begin
            if (upper[i]) begin
                lo_upper = snq_pkg::BASE_W'(i);
            end
            if (vm[i]) begin
                lo_all = snq_pkg::BASE_W'(i);
            end
        end
    end

    always_comb begin
        mode_eff           = mask_any ? snq_pkg::mode_t'(mode) : snq_pkg::MODE_NONE;
        item_next          = '0;
        item_next.note     = item_in.note;
        item_next.rem      = item_in.rem;
        if (member) begin
            item_next.valid    = item_in.valid;
            item_next.in_scale = 1'b1;
        end else begin
            unique case (mode_eff)
                snq_pkg::MODE_STEP_DN: begin
                    item_next.valid   = item_in.valid;
                    item_next.step_dn = 1'b1;
                end
                snq_pkg::MODE_STEP_UP: begin
                    item_next.valid   = item_in.valid;
                    item_next.step_up = 1'b1;
                end
                snq_pkg::MODE_SCALE_DN: begin
                    item_next.valid = item_in.valid && (|vm);
                    if (|lower) begin
                        item_next.ndeg = hi_lower;
                    end else begin
                        item_next.ndeg    = hi_all;
                        item_next.wrap_dn = 1'b1;
                    end
                end
                snq_pkg::MODE_SCALE_UP: begin
                    item_next.valid = item_in.valid && (|vm);
                    if (|upper) begin
                        item_next.ndeg = lo_upper;
                    end else begin
                        item_next.ndeg    = lo_all;
                        item_next.wrap_up = 1'b1;
                    end
                end
                default: begin
                    item_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ----- hdl/scale_note_quantizer.sv -----
// scale note quantizer
// s_ channel: one note per transfer (s_valid / s_ready). m_ channel: the
// quantized note and an in-scale flag. a note outside the scale under mode
// none or an unused mode, or with no scale member to reach, gives no transfer on m_.
// cfg_ channel: cfg_index selects base (0), mode (1) or scale_mask (2);
// cfg_ready is always high. write it only while no note is in flight.
// pipeline: a note transfer reaches m_valid through these registered stages:
// four remainder stages of four restoring steps each, one search stage
// that priority-encodes the scale mask, one output register.
// throughput: one note per cycle; all stages share one advance enable.
// when m_ready is low with a result waiting, the whole pipe holds and
// s_ready drops until the result is taken; nothing is dropped or repeated.
// reset: base 12, mode none, empty mask, pipe emptied.
module scale_note_quantizer #(
    parameter int MAX_DEGREES = snq_pkg::MAX_DEGREES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [snq_pkg::NOTE_W-1:0]         s_note,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [snq_pkg::VALUE_W-1:0] m_value,
    output logic                               m_in_scale,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [snq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [snq_pkg::MASK_W-1:0]         cfg_data
);

    localparam logic signed [snq_pkg::VALUE_W-1:0] ONE = snq_pkg::VALUE_W'(1);

    logic [snq_pkg::BASE_W-1:0]          base_reg;
    logic [snq_pkg::MODE_W-1:0]          mode_reg;
    logic [MAX_DEGREES-1:0]              mask_reg;
    logic                                mask_any_reg;
    logic [snq_pkg::BASE_W-1:0]          base_wr;
    logic                                adv;
    snq_pkg::div_item_t                  div_pipe [snq_pkg::DIV_STAGES+1];
    snq_pkg::sel_item_t                  sel;
    logic signed [snq_pkg::VALUE_W-1:0]  note_ext;
    logic signed [snq_pkg::VALUE_W-1:0]  rem_ext;
    logic signed [snq_pkg::VALUE_W-1:0]  ndeg_ext;
    logic signed [snq_pkg::VALUE_W-1:0]  base_ext;
    logic signed [snq_pkg::VALUE_W-1:0]  value_next;
    logic                                m_valid_reg;
    logic signed [snq_pkg::VALUE_W-1:0]  m_value_reg;
    logic                                m_in_scale_reg;

    assign cfg_ready = 1'b1;
    assign base_wr   = cfg_data[snq_pkg::BASE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= snq_pkg::BASE_RESET;
            mode_reg     <= snq_pkg::MODE_NONE;
            mask_reg     <= '0;
            mask_any_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (snq_pkg::cfg_reg_t'(cfg_index))
                snq_pkg::REG_BASE: begin
                    // zero or out-of-range base is ignored
                    if (base_wr != '0 &&
                        {1'b0, base_wr} < (snq_pkg::BASE_W+1)'(MAX_DEGREES)) begin
                        base_reg <= base_wr;
                    end
                end
                snq_pkg::REG_MODE: begin
                    mode_reg <= cfg_data[snq_pkg::MODE_W-1:0];
                end
                snq_pkg::REG_MASK: begin
                    mask_reg     <= cfg_data[MAX_DEGREES-1:0];
                    mask_any_reg <= |cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        div_pipe[0].valid = s_valid;
        div_pipe[0].note  = s_note;
        div_pipe[0].pend  = s_note;
        div_pipe[0].rem   = '0;
    end

    for (genvar g = 0; g < snq_pkg::DIV_STAGES; g++) begin : g_rem
        snq_rem_stage u_rem_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .base     (base_reg),
            .item_in  (div_pipe[g]),
            .item_out (div_pipe[g+1])
        );
    end

    snq_search #(
        .MAX_DEGREES (MAX_DEGREES)
    ) u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .base     (base_reg),
        .mode     (mode_reg),
        .mask     (mask_reg),
        .mask_any (mask_any_reg),
        .item_in  (div_pipe[snq_pkg::DIV_STAGES]),
        .item_out (sel)
    );

    // octave * base is note - rem, so the result is rebuilt from the note
    always_comb begin
        note_ext = signed'({{(snq_pkg::VALUE_W-snq_pkg::NOTE_W){1'b0}}, sel.note});
        rem_ext  = signed'({{(snq_pkg::VALUE_W-snq_pkg::BASE_W){1'b0}}, sel.rem});
        ndeg_ext = signed'({{(snq_pkg::VALUE_W-snq_pkg::BASE_W){1'b0}}, sel.ndeg});
        base_ext = signed'({{(snq_pkg::VALUE_W-snq_pkg::BASE_W){1'b0}}, base_reg});
        priority if (sel.in_scale) begin
            value_next = note_ext;
        end else if (sel.step_dn) begin
            value_next = note_ext - ONE;
        end else if (sel.step_up) begin
            value_next = note_ext + ONE;
        end else if (sel.wrap_dn) begin
            value_next = note_ext - rem_ext + ndeg_ext - base_ext;
        end else if (sel.wrap_up) begin
            value_next = note_ext - rem_ext + ndeg_ext + base_ext;
        end else begin
            value_next = note_ext - rem_ext + ndeg_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg    <= sel.valid;
            m_value_reg    <= value_next;
            m_in_scale_reg <= sel.in_scale;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_in_scale = m_in_scale_reg;

endmodule

// ----- hdl/snq_checker.sv -----
`include "scale_note_quantizer_macros.svh"

module snq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [snq_pkg::VALUE_W-1:0] m_value,
    input logic                               m_in_scale
);

    // a waiting result holds until its transfer
    `SNQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_in_scale))

    // the input side stalls only while a result is blocked
    `SNQ_ASSERT_SAME(a_in_stall, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))

    // a passed-through note is never negative
    `SNQ_ASSERT_SAME(a_pass_sign, aclk, aresetn, m_valid && m_in_scale, !m_value[snq_pkg::VALUE_W-1])

    // a quantized note never falls more than one octave below zero
    `SNQ_ASSERT_SAME(a_low_bound, aclk, aresetn, m_valid, m_value >= -64)

endmodule

bind scale_note_quantizer snq_checker u_snq_checker (.*);

// ----- tb/tb_scale_note_quantizer.sv -----
`timescale 1ns / 1ps

module tb_scale_note_quantizer;
    import snq_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 12;
    localparam int PHASE_NOTES   = 62;
    localparam int DIR_ROWS      = 47;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_NOTE_PRED,
        ROW_NOTE_EXP,
        ROW_NOTE_NONE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [MASK_W-1:0]         data;
        logic [NOTE_W-1:0]         note;
        logic signed [VALUE_W-1:0] exp_value;
        logic                      exp_in;
    } dir_row_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      in_scale;
    } note_result_t;

    // directed rows: typed expectations only where they are obvious
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'hFFFF, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'h0AB5, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd60, 18'sd60, 1'b1},
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'd61, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_STEP_DN), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd61, 18'sd60, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd0, 18'sd0, 1'b1},
        '{ROW_CFG, REG_MODE, 64'(MODE_STEP_UP), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd61, 18'sd62, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'hFFFF, 18'sd65536, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_SCALE_DN), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd66, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd61, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_SCALE_UP), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd70, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'hFFFF, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'h2, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_STEP_DN), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd0, -18'sd1, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_SCALE_DN), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_SCALE_UP), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd11, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'h10_0000, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'd5, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'h2, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'd7, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'd3, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd1, 18'sd1, 1'b1},
        '{ROW_CFG, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_BASE, 64'd0, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_BASE, 64'd64, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'd13, 18'sd13, 1'b1},
        '{ROW_CFG, REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_EXP, REG_BASE, 64'd0, 16'hFFFF, 18'sd65535, 1'b1},
        '{ROW_CFG, REG_MASK, 64'hBFFF_FFFF_FFFF_FFFF, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_STEP_UP), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd62, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd65519, 18'sd0, 1'b0},
        '{ROW_CFG, REG_BASE, 64'd1, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MASK, 64'h2, 16'd0, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_STEP_DN), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_PRED, REG_BASE, 64'd0, 16'd5, 18'sd0, 1'b0},
        '{ROW_CFG, REG_MODE, 64'(MODE_SCALE_UP), 16'd0, 18'sd0, 1'b0},
        '{ROW_NOTE_NONE, REG_BASE, 64'd0, 16'd5, 18'sd0, 1'b0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [NOTE_W-1:0]         s_note;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_value;
    logic                      m_in_scale;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [MASK_W-1:0]         cfg_data;

    // shadow copy of the block's registers
    logic [BASE_W-1:0] base_q;
    logic [MODE_W-1:0] mode_q;
    logic [MASK_W-1:0] mask_q;

    note_result_t expected_notes [$];
    int           errors;
    int           cycles;
    int           send_idle;
    int           recv_stall;

    scale_note_quantizer #(
        .MAX_DEGREES(MAX_DEGREES_DEF)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_note    (s_note),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_in_scale(m_in_scale),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // snaps a note onto the current scale, returns 0 when no result is due
    function automatic bit quantize_note(input logic [NOTE_W-1:0] n,
                                         output note_result_t res);
        int         b;
        int         oct;
        int         deg;
        int         k;
        logic [2:0] m;
        bit         found;
        b = int'(base_q);
        oct = int'(n) / b;
        deg = int'(n) % b;
        m = mode_q;
        res = '0;
        if (mask_q == '0)
            m = MODE_NONE;
        if (mask_q[deg]) begin
            res.value = VALUE_W'(n);
            res.in_scale = 1'b1;
            return 1'b1;
        end
        case (m)
            MODE_STEP_DN: begin
                deg--;
                if (deg < 0) begin
                    deg = b - 1;
                    oct--;
                end
            end
            MODE_STEP_UP: begin
                deg++;
                if (deg >= b) begin
                    deg = 0;
                    oct++;
                end
            end
            MODE_SCALE_DN, MODE_SCALE_UP: begin
                found = 1'b0;
                for (k = 1; k < b && !found; k++) begin
                    if (m == MODE_SCALE_DN) begin
                        deg--;
                        if (deg < 0) begin
                            deg = b - 1;
                            oct--;
                        end
                    end else begin
                        deg++;
                        if (deg >= b) begin
                            deg = 0;
                            oct++;
                        end
                    end
                    if (mask_q[deg])
                        found = 1'b1;
                end
                if (!found)
                    return 1'b0;
            end
            default: return 1'b0;
        endcase
        res.value = VALUE_W'(oct * b + deg);
        return 1'b1;
    endfunction

    // drop valid, wait for all results, then let any resultless notes clear the pipe
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_notes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_notes.size() != 0) begin
            $display("%0t: missing result, expected value %0d in_scale %0b, got none (%0d left)",
                     $time, expected_notes[0].value, expected_notes[0].in_scale,
                     expected_notes.size());
            errors += expected_notes.size();
            expected_notes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BASE: begin
                if (data[BASE_W-1:0] != '0 && int'(data[BASE_W-1:0]) < MAX_DEGREES_DEF)
                    base_q = data[BASE_W-1:0];
            end
            REG_MODE: mode_q = data[MODE_W-1:0];
            REG_MASK: mask_q = data;
            default: ;
        endcase
    endtask

    task automatic push_note(input logic [NOTE_W-1:0] n, input row_kind_t kind,
                             input logic signed [VALUE_W-1:0] exp_value, input logic exp_in);
        note_result_t res;
        s_valid <= 1'b1;
        s_note  <= n;
        do @(posedge aclk); while (!s_ready);
        case (kind)
            ROW_NOTE_EXP: expected_notes.push_back('{exp_value, exp_in});
            ROW_NOTE_PRED: begin
                if (quantize_note(n, res))
                    expected_notes.push_back(res);
            end
            default: ;
        endcase
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin : result_check
        note_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_notes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got value %0d in_scale %0b",
                         $time, m_value, m_in_scale);
                errors++;
            end else begin
                want = expected_notes.pop_front();
                if (m_value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, want.value, m_value);
                    errors++;
                end
                if (m_in_scale !== want.in_scale) begin
                    $display("%0t: in_scale mismatch, expected %0b, got %0b",
                             $time, want.in_scale, m_in_scale);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int                ph;
        int                i;
        logic [MASK_W-1:0] d;
        logic [NOTE_W-1:0] n;
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_note     = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_BASE;
        cfg_data   = '0;
        base_q     = BASE_RESET;
        mode_q     = MODE_NONE;
        mask_q     = '0;
        errors     = 0;
        cycles     = 0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG)
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            else
                push_note(DIR_TAB[i].note, DIR_TAB[i].kind, DIR_TAB[i].exp_value,
                          DIR_TAB[i].exp_in);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 20; recv_stall = 20; end
            endcase

            // upper data bits are random so that truncation of the narrow registers is exercised
            d = {$urandom, $urandom};
            case ($urandom_range(5))
                0: d[BASE_W-1:0] = BASE_W'(1);
                1: d[BASE_W-1:0] = BASE_W'(63);
                2: d[BASE_W-1:0] = BASE_W'(12);
                3: d[BASE_W-1:0] = BASE_W'($urandom_range(63));
                default: d[BASE_W-1:0] = BASE_W'($urandom_range(16, 1));
            endcase
            write_reg(REG_BASE, d);

            d = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
                d[MODE_W-1:0] = MODE_W'($urandom_range(7));
            else
                d[MODE_W-1:0] = MODE_W'($urandom_range(MODE_SCALE_UP, MODE_STEP_DN));
            write_reg(REG_MODE, d);

            case ($urandom_range(7))
                0: d = '0;
                1: d = '1;
                2: d = 64'd1 << $urandom_range(63);
                3: d = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                4: d = {$urandom, $urandom} & ('1 << base_q);
                default: d = {$urandom, $urandom};
            endcase
            write_reg(REG_MASK, d);

            for (i = 0; i < PHASE_NOTES; i++) begin
                // hold the sender off until the pipe has fully drained
                if (i == PHASE_NOTES / 2 && ph % 3 == 1)
                    settle();
                case ($urandom_range(15))
                    0: n = '0;
                    1: n = '1;
                    2, 3: n = NOTE_W'($urandom_range(255));
                    default: n = NOTE_W'($urandom_range(65535));
                endcase
                push_note(n, ROW_NOTE_PRED, '0, 1'b0);
            end
        end

        settle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/snq_pkg.sv
hdl/snq_rem_stage.sv
hdl/snq_search.sv
hdl/scale_note_quantizer.sv
hdl/snq_checker.sv
tb/tb_scale_note_quantizer.sv
